>>> hdl/lagrange_interpolation_evaluator_defines.svh
// Assertion macros shared by the Lagrange interpolation evaluator modules.
`ifndef LAGRANGE_INTERPOLATION_EVALUATOR_DEFINES_SVH
`define LAGRANGE_INTERPOLATION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LIE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lie_pkg.sv
// Shared constants, codes and command/status types of the Lagrange evaluator.
package lie_pkg;

   localparam int DEFAULT_MAX_POINTS = 16;

   localparam int COORD_W  = 16;
   localparam int QUERY_W  = 32;
   localparam int VALUE_W  = 40;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 4;
   localparam int SLOT_W   = 4;

   localparam int NUM_W   = 33;
   localparam int QUO_W   = 34;
   localparam int DVS_W   = 17;
   localparam int PM_W    = 48;
   localparam int CHUNK_W = 17;
   localparam int MULP_W  = 65;
   localparam int PROD_W  = 82;
   localparam int CNT_W   = 6;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

   localparam logic [PM_W-1:0] PM_ONE = 48'h0000_0001_0000;
   localparam logic [PM_W-1:0] PM_CAP = 48'h8000_0000_0000;

   localparam logic [63:0] VAL_POS_MAG = 64'h0000_007F_FFFF_FFFF;
   localparam logic [63:0] VAL_NEG_MAG = 64'h0000_0080_0000_0000;

   localparam logic [CNT_W-1:0] DIV_LAST = 6'd33;
   localparam logic [CNT_W-1:0] MUL_LAST = 6'd1;

   typedef struct packed {
      logic load_point;
      logic start_eval;
      logic load_i;
      logic start_factor;
      logic div_step;
      logic mul_step;
      logic mul_hi;
      logic norm;
      logic term_mul;
      logic term_acc;
      logic write_out;
   } lie_cmd_type;

   typedef struct packed {
      logic out_free;
   } lie_sts_type;

endpackage

>>> hdl/lagrange_interpolation_evaluator.sv
// Top level of the Lagrange interpolation evaluator: controller and datapath.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   func, point_index, point_x, point_y, query_x
//   rsp      out        rsp_valid/rsp_stall   value, status
//   csr      in         csr_wr_en             csr_wr_data (last_point_index)
//
// A load item is written to the point table in the cycle it is accepted. For an evaluate
// item, each factor of each point's basis term passes through the bit-serial divider and
// then the shared 48x17 multiplier.
// Reset is synchronous and clears control state only; the point table is not cleared.
// A held result does not stop the next item being accepted; only the final write waits.
module lagrange_interpolation_evaluator #(
   parameter int MAX_POINTS = lie_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lie_pkg::CFG_W-1:0]           csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [lie_pkg::SLOT_W-1:0]          req_point_index,
   input  logic signed [lie_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [lie_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [lie_pkg::QUERY_W-1:0]  req_query_x,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lie_pkg::VALUE_W-1:0]  rsp_value,
   output logic [lie_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int IW = $clog2(MAX_POINTS);

   lie_pkg::lie_cmd_type cmd;
   lie_pkg::lie_sts_type sts;
   logic [IW-1:0]        rd_addr;
   logic [IW-1:0]        last_index;

   lie_ctrl #(
      .MAX_POINTS (MAX_POINTS),
      .IW         (IW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_func   (req_func),
      .req_stall  (req_stall),
      .sts        (sts),
      .last_index (last_index),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   lie_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .IW         (IW)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_point_index (req_point_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_query_x     (req_query_x),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .sts             (sts),
      .last_index      (last_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_status      (rsp_status)
   );

endmodule

>>> hdl/lie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lie_datapath.sv
// Datapath: point table, divider, shared multiplier, accumulator and result register.
`include "lagrange_interpolation_evaluator_defines.svh"

module lie_datapath #(
   parameter int MAX_POINTS = lie_pkg::DEFAULT_MAX_POINTS,
   parameter int IW         = $clog2(MAX_POINTS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lie_pkg::CFG_W-1:0]           csr_wr_data,
   input  logic [lie_pkg::SLOT_W-1:0]          req_point_index,
   input  logic signed [lie_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [lie_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [lie_pkg::QUERY_W-1:0]  req_query_x,
   input  lie_pkg::lie_cmd_type                cmd,
   input  logic [IW-1:0]                       rd_addr,
   output lie_pkg::lie_sts_type                sts,
   output logic [IW-1:0]                       last_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lie_pkg::VALUE_W-1:0]  rsp_value,
   output logic [lie_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int SUM_W = lie_pkg::VALUE_W + IW + 1;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(lie_pkg::VAL_POS_MAG);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

   logic [lie_pkg::CFG_W-1:0] last_cfg_ff;

   logic                                 wr_en;
   logic [2*lie_pkg::COORD_W-1:0]        rd_data;
   logic signed [lie_pkg::COORD_W-1:0]   x_j;

   logic signed [lie_pkg::QUERY_W-1:0]   query_ff;
   logic signed [lie_pkg::COORD_W-1:0]   x_i_ff;
   logic [lie_pkg::COORD_W-1:0]          ymag_ff;
   logic                                 yneg_ff;
   logic                                 pneg_ff;
   logic                                 dup_ff;
   logic                                 sat_ff;
   logic [lie_pkg::QUO_W-1:0]            dq_ff;
   logic [lie_pkg::DVS_W-1:0]            rem_ff;
   logic [lie_pkg::DVS_W-1:0]            dvs_ff;
   logic [lie_pkg::PM_W-1:0]             pm_ff;
   logic [lie_pkg::PROD_W-1:0]           acc_ff;
   logic signed [SUM_W-1:0]              sum_ff;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic signed [lie_pkg::VALUE_W-1:0]   rsp_value_ff;
   logic [lie_pkg::STATUS_W-1:0]         rsp_status_ff;

   logic signed [lie_pkg::NUM_W-1:0]     num_c;
   logic signed [lie_pkg::COORD_W:0]     den_c;
   logic [lie_pkg::NUM_W-1:0]            mn_c;
   logic [lie_pkg::COORD_W:0]            md_c;
   logic [lie_pkg::QUO_W-1:0]            dividend_c;
   logic [lie_pkg::DVS_W:0]              r2_c;
   logic [lie_pkg::DVS_W:0]              diff_c;
   logic                                 ge_c;
   logic [lie_pkg::CHUNK_W-1:0]          mul_b;
   logic [lie_pkg::MULP_W-1:0]           mulp_c;
   logic [63:0]                          rnd_c;
   logic [lie_pkg::PM_W-1:0]             rq_c;
   logic [63:0]                          tmag_c;
   logic [lie_pkg::VALUE_W-1:0]          tcap_c;
   logic                                 tneg_c;
   logic                                 tsat_c;
   logic signed [lie_pkg::VALUE_W:0]     tval_c;
   logic signed [lie_pkg::VALUE_W-1:0]   fin_val_c;
   logic                                 fin_sat_c;

   // Configuration register and its clamp to the table depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_cfg_ff <= '0;
      end else if (csr_wr_en) begin
         last_cfg_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if ({4'b0, last_cfg_ff} > 8'(MAX_POINTS - 1)) begin
         last_index = IW'(MAX_POINTS - 1);
      end else begin
         last_index = IW'(last_cfg_ff);
      end
   end

   // Point table: x in the upper half, y in the lower half.
   assign wr_en = cmd.load_point && ({4'b0, req_point_index} < 8'(MAX_POINTS));

   lie_ram #(
      .WIDTH (2 * lie_pkg::COORD_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IW'(req_point_index)),
      .wr_data ({req_point_x, req_point_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign x_j = rd_data[2*lie_pkg::COORD_W-1:lie_pkg::COORD_W];

   // Factor operands: numerator in Q17.16, denominator as an integer.
   always_comb begin
      num_c = lie_pkg::NUM_W'(query_ff) - lie_pkg::NUM_W'($signed({x_j, 16'h0000}));
      den_c = (lie_pkg::COORD_W + 1)'(x_i_ff) - (lie_pkg::COORD_W + 1)'(x_j);
      mn_c  = num_c[lie_pkg::NUM_W-1] ? lie_pkg::NUM_W'(-num_c) : lie_pkg::NUM_W'(num_c);
      md_c  = den_c[lie_pkg::COORD_W] ? (lie_pkg::COORD_W + 1)'(-den_c)
                                      : (lie_pkg::COORD_W + 1)'(den_c);
      dividend_c = {mn_c, 1'b0} + lie_pkg::QUO_W'(md_c);
   end

   // One restoring division step per cycle.
   always_comb begin
      r2_c   = {rem_ff, dq_ff[lie_pkg::QUO_W-1]};
      diff_c = r2_c - {1'b0, dvs_ff};
      ge_c   = r2_c >= {1'b0, dvs_ff};
   end

   // Shared multiplier: product magnitude by a quotient chunk, or by |y|.
   always_comb begin
      if (cmd.term_mul) begin
         mul_b = {1'b0, ymag_ff};
      end else if (cmd.mul_hi) begin
         mul_b = dq_ff[lie_pkg::QUO_W-1:lie_pkg::CHUNK_W];
      end else begin
         mul_b = dq_ff[lie_pkg::CHUNK_W-1:0];
      end
      mulp_c = lie_pkg::MULP_W'(pm_ff) * lie_pkg::MULP_W'(mul_b);
   end

   // Rounding of the running product back to Q32.16.
   always_comb begin
      rnd_c = {1'b0, acc_ff[62:0]} + 64'h8000;
      rq_c  = rnd_c[63:16];
   end

   // Clamp of one term to the result range.
   always_comb begin
      tmag_c = acc_ff[63:0];
      tneg_c = pneg_ff ^ yneg_ff;
      tsat_c = 1'b0;
      if (tneg_c) begin
         if (tmag_c > lie_pkg::VAL_NEG_MAG) begin
            tcap_c = lie_pkg::VALUE_W'(lie_pkg::VAL_NEG_MAG);
            tsat_c = 1'b1;
         end else begin
            tcap_c = lie_pkg::VALUE_W'(tmag_c);
         end
         tval_c = -$signed({1'b0, tcap_c});
      end else begin
         if (tmag_c > lie_pkg::VAL_POS_MAG) begin
            tcap_c = lie_pkg::VALUE_W'(lie_pkg::VAL_POS_MAG);
            tsat_c = 1'b1;
         end else begin
            tcap_c = lie_pkg::VALUE_W'(tmag_c);
         end
         tval_c = $signed({1'b0, tcap_c});
      end
   end

   // Final clamp of the sum.
   always_comb begin
      fin_sat_c = 1'b0;
      if (sum_ff > SUM_MAX) begin
         fin_val_c = lie_pkg::VALUE_W'(SUM_MAX);
         fin_sat_c = 1'b1;
      end else if (sum_ff < SUM_MIN) begin
         fin_val_c = lie_pkg::VALUE_W'(SUM_MIN);
         fin_sat_c = 1'b1;
      end else begin
         fin_val_c = lie_pkg::VALUE_W'(sum_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_eval) begin
         query_ff <= req_query_x;
         sum_ff   <= '0;
         dup_ff   <= 1'b0;
         sat_ff   <= 1'b0;
      end
      if (cmd.load_i) begin
         x_i_ff  <= rd_data[2*lie_pkg::COORD_W-1:lie_pkg::COORD_W];
         yneg_ff <= rd_data[lie_pkg::COORD_W-1];
         ymag_ff <= rd_data[lie_pkg::COORD_W-1] ? lie_pkg::COORD_W'(-rd_data[15:0])
                                                : rd_data[15:0];
         pm_ff   <= lie_pkg::PM_ONE;
         pneg_ff <= 1'b0;
      end
      if (cmd.start_factor) begin
         dq_ff   <= dividend_c;
         rem_ff  <= '0;
         dvs_ff  <= {md_c[lie_pkg::COORD_W-1:0], 1'b0};
         pneg_ff <= pneg_ff ^ (num_c[lie_pkg::NUM_W-1] != den_c[lie_pkg::COORD_W]);
         if (den_c == '0) begin
            dup_ff <= 1'b1;
         end
      end
      if (cmd.div_step) begin
         rem_ff <= ge_c ? diff_c[lie_pkg::DVS_W-1:0] : r2_c[lie_pkg::DVS_W-1:0];
         dq_ff  <= {dq_ff[lie_pkg::QUO_W-2:0], ge_c};
      end
      if (cmd.mul_step) begin
         if (cmd.mul_hi) begin
            acc_ff <= lie_pkg::PROD_W'(mulp_c);
         end else begin
            acc_ff <= (acc_ff << lie_pkg::CHUNK_W) + lie_pkg::PROD_W'(mulp_c);
         end
      end
      if (cmd.term_mul) begin
         acc_ff <= lie_pkg::PROD_W'(mulp_c);
      end
      if (cmd.norm) begin
         // A raw product at or above 2^63 saturates as well as a rounded one above the cap.
         if (|acc_ff[lie_pkg::PROD_W-1:63]) begin
            pm_ff  <= lie_pkg::PM_CAP;
            sat_ff <= 1'b1;
         end else if (rq_c > lie_pkg::PM_CAP) begin
            pm_ff  <= lie_pkg::PM_CAP;
            sat_ff <= 1'b1;
         end else begin
            pm_ff <= rq_c;
         end
      end
      if (cmd.term_acc) begin
         sum_ff <= sum_ff + SUM_W'(tval_c);
         if (tsat_c) begin
            sat_ff <= 1'b1;
         end
      end
      if (cmd.write_out) begin
         if (dup_ff) begin
            rsp_value_ff  <= '0;
            rsp_status_ff <= lie_pkg::STATUS_DUP;
         end else begin
            rsp_value_ff  <= fin_val_c;
            rsp_status_ff <= (sat_ff || fin_sat_c) ? lie_pkg::STATUS_SAT : lie_pkg::STATUS_OK;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_status   = rsp_status_ff;

   `LIE_ASSERT_NEXT(a_pm_capped, clock, reset, cmd.norm, pm_ff <= lie_pkg::PM_CAP, "product magnitude above cap")
   `LIE_ASSERT_NOW(a_dup_zero, clock, reset, rsp_valid_ff && rsp_status_ff == lie_pkg::STATUS_DUP, rsp_value_ff == '0, "duplicate result with nonzero value")
   `LIE_ASSERT_NOW(a_write_free, clock, reset, cmd.write_out, !rsp_valid_ff || !rsp_stall, "result overwritten while held")

endmodule

>>> hdl/lie_ctrl.sv
// Controller: sequences loads, factor divisions, products and term accumulation.
`include "lagrange_interpolation_evaluator_defines.svh"

module lie_ctrl #(
   parameter int MAX_POINTS = lie_pkg::DEFAULT_MAX_POINTS,
   parameter int IW         = $clog2(MAX_POINTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_func,
   output logic                  req_stall,
   input  lie_pkg::lie_sts_type  sts,
   input  logic [IW-1:0]         last_index,
   output lie_pkg::lie_cmd_type  cmd,
   output logic [IW-1:0]         rd_addr
);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_RDI  = 11'b000_0000_0010,
      ST_LDI  = 11'b000_0000_0100,
      ST_RDJ  = 11'b000_0000_1000,
      ST_LDJ  = 11'b000_0001_0000,
      ST_DIV  = 11'b000_0010_0000,
      ST_MUL  = 11'b000_0100_0000,
      ST_NRM  = 11'b000_1000_0000,
      ST_TMUL = 11'b001_0000_0000,
      ST_TACC = 11'b010_0000_0000,
      ST_FIN  = 11'b100_0000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic [IW-1:0]             i_ff, i_in;
   logic [IW-1:0]             j_ff, j_in;
   logic [lie_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == lie_pkg::FUNC_EVAL) begin
                  cmd.start_eval = 1'b1;
                  i_in           = '0;
                  j_in           = '0;
                  state_in       = ST_RDI;
               end else begin
                  cmd.load_point = 1'b1;
               end
            end
         end
         ST_RDI: begin
            state_in = ST_LDI;
         end
         ST_LDI: begin
            cmd.load_i = 1'b1;
            j_in       = '0;
            state_in   = ST_RDJ;
         end
         ST_RDJ: begin
            // The own point contributes no factor.
            if (j_ff == i_ff) begin
               if (j_ff == last_index) begin
                  state_in = ST_TMUL;
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end else begin
               state_in = ST_LDJ;
            end
         end
         ST_LDJ: begin
            cmd.start_factor = 1'b1;
            cnt_in           = '0;
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == lie_pkg::DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff + lie_pkg::CNT_W'(1);
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            cmd.mul_hi   = (cnt_ff == '0);
            if (cnt_ff == lie_pkg::MUL_LAST) begin
               state_in = ST_NRM;
            end else begin
               cnt_in = cnt_ff + lie_pkg::CNT_W'(1);
            end
         end
         ST_NRM: begin
            cmd.norm = 1'b1;
            if (j_ff == last_index) begin
               state_in = ST_TMUL;
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = ST_RDJ;
            end
         end
         ST_TMUL: begin
            cmd.term_mul = 1'b1;
            state_in     = ST_TACC;
         end
         ST_TACC: begin
            cmd.term_acc = 1'b1;
            if (i_ff == last_index) begin
               state_in = ST_FIN;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_RDI;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.write_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rd_addr   = (state_ff == ST_RDI) ? i_ff : j_ff;

   `LIE_ASSERT_NOW(a_no_self_factor, clock, reset, state_ff == ST_LDJ, j_ff != i_ff,
                   "factor started with j equal to i")
   `LIE_ASSERT_NOW(a_counters_in_range, clock, reset, state_ff != ST_IDLE,
                   i_ff <= last_index && j_ff <= last_index, "point counter beyond last point")
   `LIE_ASSERT_NEXT(a_eval_starts, clock, reset,
                    state_ff == ST_IDLE && req_valid && req_func == lie_pkg::FUNC_EVAL,
                    state_ff == ST_RDI, "evaluate item did not start a pass")

endmodule

>>> tb/lie_checker.sv
// Checker for the Lagrange evaluator: tracks the point table, predicts each result and compares.
module lie_checker
   import lie_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CFG_W-1:0]           csr_wr_data,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_func,
   input  logic [SLOT_W-1:0]          req_point_index,
   input  logic signed [COORD_W-1:0]  req_point_x,
   input  logic signed [COORD_W-1:0]  req_point_y,
   input  logic signed [QUERY_W-1:0]  req_query_x,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [VALUE_W-1:0]  rsp_value,
   input  logic [STATUS_W-1:0]        rsp_status,
   output int                         errors,
   output int                         pending,
   output int                         load_count,
   output int                         eval_count,
   output int                         sat_count,
   output int                         dup_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS = DEFAULT_MAX_POINTS;
   localparam logic [63:0] RAW_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } interp_result_type;

   logic signed [COORD_W-1:0] abscissa [NPTS];
   logic signed [COORD_W-1:0] ordinate [NPTS];
   logic [CFG_W-1:0]          last_point;
   interp_result_type         awaited_values [$];

   initial begin
      errors = 0;
      load_count = 0;
      eval_count = 0;
      sat_count = 0;
      dup_count = 0;
   end

   assign pending = awaited_values.size();

   task automatic report(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   function automatic logic [63:0] mag(input longint a);
      return a < 0 ? 64'(-a) : 64'(a);
   endfunction

   // Clamps a sign and magnitude to the 40-bit signed range.
   function automatic longint clamp40(input bit neg, input logic [63:0] m, inout bit sat);
      if (neg) begin
         if (m > VAL_NEG_MAG) begin
            m = VAL_NEG_MAG;
            sat = 1'b1;
         end
         return -longint'(m);
      end
      if (m > VAL_POS_MAG) begin
         m = VAL_POS_MAG;
         sat = 1'b1;
      end
      return longint'(m);
   endfunction

   function automatic interp_result_type interpolate(input logic signed [QUERY_W-1:0] q);
      interp_result_type r;
      int             last;
      bit             sat;
      bit             pneg;
      longint         sum, num, den, y;
      logic [63:0]    pm, mn, md, rm;
      last = (last_point > NPTS - 1) ? NPTS - 1 : last_point;
      sat = 1'b0;
      sum = 0;
      for (int i = 0; i <= last; i++)
         for (int j = i + 1; j <= last; j++)
            if (abscissa[i] == abscissa[j]) begin
               r.value = '0;
               r.status = STATUS_DUP;
               return r;
            end
      for (int i = 0; i <= last; i++) begin
         pm = 64'(PM_ONE);
         pneg = 1'b0;
         y = longint'(ordinate[i]);
         for (int j = 0; j <= last; j++) begin
            if (j != i) begin
               num = longint'(q) - longint'(abscissa[j]) * 65536;
               den = longint'(abscissa[i]) - longint'(abscissa[j]);
               mn = mag(num);
               md = mag(den);
               // Round to nearest, ties away from zero, on the magnitudes.
               rm = (2 * mn + md) / (2 * md);
               if ((num < 0) != (den < 0))
                  pneg = !pneg;
               if (rm != 0 && pm > RAW_LIMIT / rm) begin
                  pm = 64'(PM_CAP);
                  sat = 1'b1;
               end else begin
                  pm = (pm * rm + 64'd32768) >> 16;
                  if (pm > 64'(PM_CAP)) begin
                     pm = 64'(PM_CAP);
                     sat = 1'b1;
                  end
               end
            end
         end
         sum += clamp40(pneg != (y < 0), pm * mag(y), sat);
      end
      sum = clamp40(sum < 0, mag(sum), sat);
      r.value = sum[VALUE_W-1:0];
      r.status = sat ? STATUS_SAT : STATUS_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      interp_result_type want;
      if (reset) begin
         last_point = '0;
         awaited_values.delete();
      end else begin
         if (csr_wr_en)
            last_point = csr_wr_data;
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_LOAD) begin
               abscissa[req_point_index] = req_point_x;
               ordinate[req_point_index] = req_point_y;
               load_count++;
            end else begin
               want = interpolate(req_query_x);
               awaited_values.push_back(want);
               eval_count++;
               if (want.status == STATUS_SAT)
                  sat_count++;
               if (want.status == STATUS_DUP)
                  dup_count++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_values.size() == 0) begin
               report($sformatf("unexpected result value=%h status=%0d", rsp_value, rsp_status));
            end else begin
               want = awaited_values.pop_front();
               if (rsp_value !== want.value)
                  report($sformatf("value %h, wanted %h", rsp_value, want.value));
               if (rsp_status !== want.status)
                  report($sformatf("status %0d, wanted %0d", rsp_status, want.status));
            end
         end
      end
   end

endmodule

>>> tb/tb_top.sv
// Top of the Lagrange evaluator testbench: clock, reset, stimulus and verdict.
module tb_top;
   import lie_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CFG_W-1:0]           csr_wr_data;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_func;
   logic [SLOT_W-1:0]          req_point_index;
   logic signed [COORD_W-1:0]  req_point_x;
   logic signed [COORD_W-1:0]  req_point_y;
   logic signed [QUERY_W-1:0]  req_query_x;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [VALUE_W-1:0]  rsp_value;
   logic [STATUS_W-1:0]        rsp_status;

   int errors, pending, load_count, eval_count, sat_count, dup_count;
   bit calm;
   int sent;

   lagrange_interpolation_evaluator dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_point_index(req_point_index), .req_point_x(req_point_x),
      .req_point_y(req_point_y), .req_query_x(req_query_x),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   lie_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_point_index(req_point_index), .req_point_x(req_point_x),
      .req_point_y(req_point_y), .req_query_x(req_query_x),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status),
      .errors(errors), .pending(pending), .load_count(load_count),
      .eval_count(eval_count), .sat_count(sat_count), .dup_count(dup_count)
   );

   // The clock starts low so that no rising edge falls at time zero.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock)
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);

   // Presents one item, sometimes after a random gap, and returns once it is taken.
   task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                            input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input logic [QUERY_W-1:0] q);
      int gap;
      gap = (!calm && $urandom_range(0, 99) < 34) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_point_index <= slot;
      req_point_x <= px;
      req_point_y <= py;
      req_query_x <= q;
      forever begin
         @(negedge clock);
         if (!req_stall) begin
            @(posedge clock);
            break;
         end
      end
      sent++;
   endtask

   task automatic load_point(input int slot, input int px, input int py);
      send_item(FUNC_LOAD, SLOT_W'(slot), COORD_W'(px), COORD_W'(py), '0);
   endtask

   task automatic evaluate_at(input logic [QUERY_W-1:0] q);
      send_item(FUNC_EVAL, '0, '0, '0, q);
   endtask

   // Holds the sender back until every result is in, then lets the block settle.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_last_point(input int last);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= CFG_W'(last);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item;
      int slot;
      if ($urandom_range(0, 99) < 45) begin
         slot = $urandom_range(0, 15);
         if ($urandom_range(0, 1))
            load_point(slot, $urandom, $urandom);
         else
            load_point(slot, $urandom_range(0, 16) - 8, $urandom);
      end else begin
         case ($urandom_range(0, 2))
            0: evaluate_at($urandom);
            1: evaluate_at(($urandom_range(0, 64) - 32) * 65536 + $urandom_range(0, 3) - 1);
            default: evaluate_at($urandom_range(0, 2048) - 1024);
         endcase
      end
   endtask

   initial begin
      int last, count;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_func <= FUNC_LOAD;
      req_point_index <= '0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_query_x <= '0;
      rsp_stall <= 1'b0;
      calm = 1'b0;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every slot is written before any evaluation reads it.
      for (int i = 0; i < 16; i++)
         load_point(i, i * 3 - 20, (i == 3) ? 32767 : (i == 7) ? -32768 : i * 1000 - 7000);
      set_last_point(15);
      evaluate_at(32'h7FFF_FFFF);
      evaluate_at(32'h8000_0000);
      set_last_point(0);
      evaluate_at(32'h0001_8000);
      set_last_point(1);
      load_point(1, -20, 5);
      evaluate_at(32'h0000_4000);
      load_point(0, -32768, -32768);
      load_point(1, 32767, 32767);
      evaluate_at('0);

      // Random phases, each with its own point count.
      count = 0;
      for (int phase = 0; count < 525; phase++) begin
         last = ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 5);
         set_last_point(last);
         calm = (phase == 5);
         for (int k = 0; k < ((last == 15) ? 8 : 25); k++) begin
            random_item();
            count++;
         end
         calm = 1'b0;
      end
      drain();

      $display("Covered %0d items: %0d loads and %0d evaluations (%0d saturated, %0d duplicate abscissa).",
               sent, load_count, eval_count, sat_count, dup_count);
      if (errors == 0 && pending == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
